// File: hdl/deploy_command_responder_core_defines.svh
// assertion helpers for the deploy command responder
`ifndef DEPLOY_COMMAND_RESPONDER_CORE_DEFINES_SVH
`define DEPLOY_COMMAND_RESPONDER_CORE_DEFINES_SVH

// checked only out of reset
`define DCR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked during reset as well
`define DCR_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/dcr_pkg.sv
// ----------------------------------------------------------------------------
// dcr_pkg
// Command codes, register indexes, reset values and shared types of the
// deploy command responder.
// ----------------------------------------------------------------------------
`default_nettype none

package dcr_pkg;

	localparam logic OP_COMMAND = 1'b0;
	localparam logic OP_POLL    = 1'b1;

	localparam logic [7:0] CMD_DEPLOY_FIRST   = 8'hA1;
	localparam logic [7:0] CMD_DEPLOY_LAST    = 8'hA4;
	localparam logic [7:0] CMD_SEQUENTIAL     = 8'hA5;
	localparam logic [7:0] CMD_NOP_A9         = 8'hA9;
	localparam logic [7:0] CMD_NOP_AA         = 8'hAA;
	localparam logic [7:0] CMD_NOP_AD         = 8'hAD;
	localparam logic [7:0] CMD_COUNT_FIRST    = 8'hB0;
	localparam logic [7:0] CMD_COUNT_LAST     = 8'hB3;
	localparam logic [7:0] CMD_TIMER_FIRST    = 8'hB4;
	localparam logic [7:0] CMD_TIMER_LAST     = 8'hB7;
	localparam logic [7:0] CMD_OVERRIDE_FIRST = 8'hBA;
	localparam logic [7:0] CMD_OVERRIDE_LAST  = 8'hBD;
	localparam logic [7:0] CMD_TEMPERATURE    = 8'hC0;
	localparam logic [7:0] CMD_STATUS         = 8'hC3;

	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t CFG_BURN_STEP   = 2'd0;
	localparam cfg_index_t CFG_TEMPERATURE = 2'd1;
	localparam cfg_index_t CFG_STATUS      = 2'd2;

	localparam logic [15:0] BURN_STEP_RESET   = 16'd3200;
	localparam logic [15:0] TEMPERATURE_RESET = 16'd1023;
	localparam logic [15:0] STATUS_RESET      = 16'hFFFF;

	localparam int          NUM_FLAGS = 9;
	localparam logic [3:0]  FLAG_SEQ  = 4'd8;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_DEPLOY,
		ACT_SEQUENTIAL,
		ACT_REPORT_COUNT,
		ACT_REPORT_TIMER,
		ACT_TEMPERATURE,
		ACT_STATUS
	} action_t;

	typedef struct packed {
		action_t    action;
		logic [1:0] ant;
		logic       override;
	} decode_t;

	typedef struct packed {
		logic [15:0] burn_step;
		logic [15:0] temperature_word;
		logic [15:0] status_word;
	} cfg_t;

endpackage

`default_nettype wire

// File: hdl/dcr_if.sv
// ----------------------------------------------------------------------------
// dcr_if
// Valid/ready channels of the deploy command responder: item, result and
// configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcr_item_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] cmd;
	logic [7:0] param;

	modport source (output valid, op, cmd, param, input ready);
	modport sink (input valid, op, cmd, param, output ready);
endinterface

interface dcr_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  resp_high;
	logic [7:0]  resp_low;
	logic [23:0] burn_time;

	modport source (output valid, resp_high, resp_low, burn_time, input ready);
	modport sink (input valid, resp_high, resp_low, burn_time, output ready);
endinterface

interface dcr_cfg_if;
	logic                valid;
	logic                ready;
	dcr_pkg::cfg_index_t index;
	logic [15:0]         data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/deploy_command_responder_core.sv
// ----------------------------------------------------------------------------
// deploy_command_responder_core
// Antenna deployer command responder: stores commands, runs poll passes and
// returns the response bytes and burn time after every beat.
// ----------------------------------------------------------------------------
// One result beat for every item beat, in order. Items are taken one per
// cycle while results are being drained; each item is held in an input
// register and then applied to the command state in a single
// read-modify-write that also loads the result register, which presents it.
// Throughput is bounded only by the result side: while a result waits, one
// more item is still taken into the input register. Configuration writes are
// always ready and take effect on the next cycle.
`default_nettype none
`include "deploy_command_responder_core_defines.svh"

module deploy_command_responder_core #(
	parameter int NUM_ANTENNAS = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	dcr_item_if.sink      item,
	dcr_result_if.source  result,
	dcr_cfg_if.sink       cfg
);

	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  cmd_s1;
	logic [7:0]  param_s1;
	logic        valid_s2;
	logic [15:0] resp_s2;
	logic [23:0] burn_s2;
	logic        advance;
	logic [15:0] resp_next;
	logic [23:0] burn_next;

	dcr_pkg::cfg_t regs;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	dcr_cfg_regs u_cfg_regs (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.regs(regs)
	);

	dcr_exec #(
		.NUM_ANTENNAS(NUM_ANTENNAS)
	) u_exec (
		.clk(clk),
		.arst_n(arst_n),
		.apply(advance),
		.op(op_s1),
		.cmd(cmd_s1),
		.param(param_s1),
		.regs(regs),
		.resp_next(resp_next),
		.burn_next(burn_next)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1    <= item.op;
			cmd_s1   <= item.cmd;
			param_s1 <= item.param;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			resp_s2 <= resp_next;
			burn_s2 <= burn_next;
		end
	end

	assign result.valid     = valid_s2;
	assign result.resp_high = resp_s2[15:8];
	assign result.resp_low  = resp_s2[7:0];
	assign result.burn_time = burn_s2;

	`DCR_ASSERT_RST(a_no_result_in_reset, !arst_n |-> !result.valid, "result valid in reset")
	`DCR_ASSERT(a_result_from_stage, $rose(result.valid) |-> $past(valid_s1), "result without item")
	`DCR_ASSERT(a_stage_holds, valid_s1 && valid_s2 && !result.ready |=> valid_s1 && $stable(cmd_s1), "input stage lost beat")

endmodule

`default_nettype wire

// File: hdl/dcr_decode.sv
// ----------------------------------------------------------------------------
// dcr_decode
// Decodes the stored command byte into action, antenna and override flag.
// ----------------------------------------------------------------------------
`default_nettype none

module dcr_decode #(
	parameter int NUM_ANTENNAS = 4
) (
	input  logic [7:0]       cmd,
	output dcr_pkg::decode_t dec
);

	logic [7:0] offset;

	always_comb begin
		offset       = 8'd0;
		dec.action   = dcr_pkg::ACT_NONE;
		dec.override = 1'b0;
		unique case (cmd) inside
			[dcr_pkg::CMD_DEPLOY_FIRST:dcr_pkg::CMD_DEPLOY_LAST]: begin
				offset     = cmd - dcr_pkg::CMD_DEPLOY_FIRST;
				dec.action = dcr_pkg::ACT_DEPLOY;
			end
			[dcr_pkg::CMD_OVERRIDE_FIRST:dcr_pkg::CMD_OVERRIDE_LAST]: begin
				offset       = cmd - dcr_pkg::CMD_OVERRIDE_FIRST;
				dec.action   = dcr_pkg::ACT_DEPLOY;
				dec.override = 1'b1;
			end
			dcr_pkg::CMD_SEQUENTIAL: begin
				dec.action = dcr_pkg::ACT_SEQUENTIAL;
			end
			[dcr_pkg::CMD_COUNT_FIRST:dcr_pkg::CMD_COUNT_LAST]: begin
				offset     = cmd - dcr_pkg::CMD_COUNT_FIRST;
				dec.action = dcr_pkg::ACT_REPORT_COUNT;
			end
			[dcr_pkg::CMD_TIMER_FIRST:dcr_pkg::CMD_TIMER_LAST]: begin
				offset     = cmd - dcr_pkg::CMD_TIMER_FIRST;
				dec.action = dcr_pkg::ACT_REPORT_TIMER;
			end
			dcr_pkg::CMD_TEMPERATURE: begin
				dec.action = dcr_pkg::ACT_TEMPERATURE;
			end
			dcr_pkg::CMD_STATUS: begin
				dec.action = dcr_pkg::ACT_STATUS;
			end
			dcr_pkg::CMD_NOP_A9, dcr_pkg::CMD_NOP_AA, dcr_pkg::CMD_NOP_AD: begin
				dec.action = dcr_pkg::ACT_NONE;
			end
			default: begin
				dec.action = dcr_pkg::ACT_NONE;
			end
		endcase
		dec.ant = offset[1:0];
		// antenna codes past the fitted count are no-ops
		if (int'(offset) >= NUM_ANTENNAS) begin
			dec.action = dcr_pkg::ACT_NONE;
		end
	end

endmodule

`default_nettype wire

// File: hdl/dcr_cfg_regs.sv
// ----------------------------------------------------------------------------
// dcr_cfg_regs
// Burn step, temperature and status registers behind the configuration
// write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dcr_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	dcr_cfg_if.sink       cfg,
	output dcr_pkg::cfg_t regs
);

	dcr_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.burn_step        <= dcr_pkg::BURN_STEP_RESET;
			regs_q.temperature_word <= dcr_pkg::TEMPERATURE_RESET;
			regs_q.status_word      <= dcr_pkg::STATUS_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				dcr_pkg::CFG_BURN_STEP:   regs_q.burn_step        <= cfg.data;
				dcr_pkg::CFG_TEMPERATURE: regs_q.temperature_word <= cfg.data;
				dcr_pkg::CFG_STATUS:      regs_q.status_word      <= cfg.data;
				default: begin
					// unmapped index, beat dropped
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/dcr_exec.sv
// ----------------------------------------------------------------------------
// dcr_exec
// Command state, antenna counters and timers; applies one beat per cycle
// when apply is high and presents the response and burn time the beat leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module dcr_exec #(
	parameter int NUM_ANTENNAS = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          apply,
	input  logic          op,
	input  logic [7:0]    cmd,
	input  logic [7:0]    param,
	input  dcr_pkg::cfg_t regs,
	output logic [15:0]   resp_next,
	output logic [23:0]   burn_next
);

	localparam int SEQ_W = (NUM_ANTENNAS > 1) ? $clog2(NUM_ANTENNAS) : 1;
	localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(NUM_ANTENNAS - 1);
	localparam logic [SEQ_W:0]   SEQ_LIMIT = (SEQ_W + 1)'(NUM_ANTENNAS);

	logic [7:0]                    cmd_q, cmd_d;
	logic [7:0]                    param_q, param_d;
	logic [dcr_pkg::NUM_FLAGS-1:0] flags_q, flags_d;
	logic [7:0]                    count_q [NUM_ANTENNAS];
	logic [7:0]                    count_d [NUM_ANTENNAS];
	logic [15:0]                   timer_q [NUM_ANTENNAS];
	logic [15:0]                   timer_d [NUM_ANTENNAS];
	logic [SEQ_W-1:0]              seq_q, seq_d;
	logic [23:0]                   burn_q, burn_d;
	logic [15:0]                   resp_q, resp_d;

	dcr_pkg::decode_t dec;
	logic [3:0]       flag_idx;
	logic [23:0]      burn_prod;

	dcr_decode #(
		.NUM_ANTENNAS(NUM_ANTENNAS)
	) u_decode (
		.cmd(cmd_q),
		.dec(dec)
	);

	assign flag_idx  = {1'b0, dec.override, dec.ant};
	assign burn_prod = 24'(param_q) * 24'(regs.burn_step);

	always_comb begin
		cmd_d   = cmd_q;
		param_d = param_q;
		flags_d = flags_q;
		count_d = count_q;
		timer_d = timer_q;
		seq_d   = seq_q;
		burn_d  = burn_q;
		resp_d  = resp_q;
		if (op == dcr_pkg::OP_COMMAND) begin
			cmd_d   = cmd;
			param_d = param;
			flags_d = '0;
		end else begin
			case (dec.action)
				dcr_pkg::ACT_DEPLOY: begin
					for (int i = 0; i < NUM_ANTENNAS; i++) begin
						if (int'(dec.ant) == i) begin
							if (!flags_q[flag_idx]) begin
								count_d[i] = count_q[i] + 8'd1;
							end
							timer_d[i] = timer_q[i] + 16'd1;
						end
					end
					if (!flags_q[flag_idx]) begin
						flags_d[flag_idx] = 1'b1;
						burn_d            = burn_prod;
					end
					resp_d = 16'd0;
				end
				dcr_pkg::ACT_SEQUENTIAL: begin
					if (!flags_q[dcr_pkg::FLAG_SEQ]) begin
						if ({1'b0, seq_q} < SEQ_LIMIT) begin
							for (int i = 0; i < NUM_ANTENNAS; i++) begin
								if (int'(seq_q) == i) begin
									count_d[i] = count_q[i] + 8'd1;
								end
							end
							seq_d = (seq_q == SEQ_LAST) ? '0 : seq_q + 1'b1;
						end else begin
							seq_d = '0;
						end
						flags_d[dcr_pkg::FLAG_SEQ] = 1'b1;
						burn_d                     = burn_prod;
					end
					resp_d = 16'd0;
				end
				dcr_pkg::ACT_REPORT_COUNT: begin
					resp_d = 16'd0;
					for (int i = 0; i < NUM_ANTENNAS; i++) begin
						if (int'(dec.ant) == i) begin
							resp_d = {count_q[i], 8'h00};
						end
					end
				end
				dcr_pkg::ACT_REPORT_TIMER: begin
					resp_d = 16'd0;
					// timer is cleared on read
					for (int i = 0; i < NUM_ANTENNAS; i++) begin
						if (int'(dec.ant) == i) begin
							resp_d     = timer_q[i];
							timer_d[i] = 16'd0;
						end
					end
				end
				dcr_pkg::ACT_TEMPERATURE: resp_d = regs.temperature_word;
				dcr_pkg::ACT_STATUS:      resp_d = regs.status_word;
				default:                  resp_d = 16'd0;
			endcase
		end
	end

	assign resp_next = resp_d;
	assign burn_next = burn_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= '0;
			param_q <= '0;
			flags_q <= '0;
			seq_q   <= '0;
			burn_q  <= '0;
			resp_q  <= '0;
			for (int i = 0; i < NUM_ANTENNAS; i++) begin
				count_q[i] <= '0;
				timer_q[i] <= '0;
			end
		end else if (apply) begin
			cmd_q   <= cmd_d;
			param_q <= param_d;
			flags_q <= flags_d;
			seq_q   <= seq_d;
			burn_q  <= burn_d;
			resp_q  <= resp_d;
			count_q <= count_d;
			timer_q <= timer_d;
		end
	end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the deploy command responder: command and poll beats
// go in with random bursts and gaps, and every response beat is checked against
// a cycle-free model of the command state under several register settings.
// ----------------------------------------------------------------------------

module tb_top;

	import dcr_pkg::*;

	localparam int NUM_ANT = 4;

	typedef struct {
		logic       op;
		logic [7:0] cmd;
		logic [7:0] param;
	} beat_t;

	typedef struct packed {
		logic [7:0]  hi;
		logic [7:0]  lo;
		logic [23:0] burn;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n;

	dcr_item_if   item_ch ();
	dcr_result_if result_ch ();
	dcr_cfg_if    cfg_ch ();

	deploy_command_responder_core #(
		.NUM_ANTENNAS(NUM_ANT)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch),
		.cfg   (cfg_ch)
	);

	always #1 clk = ~clk;

	// model of the responder state
	cfg_t        cfg_now;
	logic [7:0]  held_cmd;
	logic [7:0]  held_param;
	logic [8:0]  once_flags;
	logic [7:0]  ant_count [NUM_ANT];
	logic [15:0] ant_timer [NUM_ANT];
	logic [1:0]  seq_ant;
	logic [23:0] burn_hold;
	logic [15:0] resp_word;

	beat_t  pending_beats [$];
	reply_t replies_due [$];
	int     n_issued;
	int     n_replies;
	int     mismatches;

	function automatic reply_t respond_to_beat(logic op, logic [7:0] cmd, logic [7:0] param);
		action_t act;
		logic [1:0] ant;
		int flag;
		act = ACT_NONE;
		ant = '0;
		flag = 0;
		if (op == OP_COMMAND) begin
			held_cmd = cmd;
			held_param = param;
			once_flags = '0;
		end else begin
			if (held_cmd >= CMD_DEPLOY_FIRST && held_cmd <= CMD_DEPLOY_LAST) begin
				act = ACT_DEPLOY;
				ant = 2'(held_cmd - CMD_DEPLOY_FIRST);
				flag = ant;
			end else if (held_cmd >= CMD_OVERRIDE_FIRST && held_cmd <= CMD_OVERRIDE_LAST) begin
				act = ACT_DEPLOY;
				ant = 2'(held_cmd - CMD_OVERRIDE_FIRST);
				flag = 4 + ant;
			end else if (held_cmd == CMD_SEQUENTIAL) begin
				act = ACT_SEQUENTIAL;
			end else if (held_cmd >= CMD_COUNT_FIRST && held_cmd <= CMD_COUNT_LAST) begin
				act = ACT_REPORT_COUNT;
				ant = 2'(held_cmd - CMD_COUNT_FIRST);
			end else if (held_cmd >= CMD_TIMER_FIRST && held_cmd <= CMD_TIMER_LAST) begin
				act = ACT_REPORT_TIMER;
				ant = 2'(held_cmd - CMD_TIMER_FIRST);
			end else if (held_cmd == CMD_TEMPERATURE) begin
				act = ACT_TEMPERATURE;
			end else if (held_cmd == CMD_STATUS) begin
				act = ACT_STATUS;
			end
			case (act)
				ACT_DEPLOY: begin
					if (!once_flags[flag]) begin
						ant_count[ant] = ant_count[ant] + 8'd1;
						once_flags[flag] = 1'b1;
						burn_hold = 24'(held_param) * 24'(cfg_now.burn_step);
					end
					ant_timer[ant] = ant_timer[ant] + 16'd1;
					resp_word = '0;
				end
				ACT_SEQUENTIAL: begin
					if (!once_flags[FLAG_SEQ]) begin
						ant_count[seq_ant] = ant_count[seq_ant] + 8'd1;
						seq_ant = (seq_ant == 2'(NUM_ANT - 1)) ? 2'd0 : seq_ant + 2'd1;
						once_flags[FLAG_SEQ] = 1'b1;
						burn_hold = 24'(held_param) * 24'(cfg_now.burn_step);
					end
					resp_word = '0;
				end
				ACT_REPORT_COUNT: resp_word = {ant_count[ant], 8'h00};
				ACT_REPORT_TIMER: begin
					resp_word = ant_timer[ant];
					ant_timer[ant] = '0;
				end
				ACT_TEMPERATURE: resp_word = cfg_now.temperature_word;
				ACT_STATUS:      resp_word = cfg_now.status_word;
				default:         resp_word = '0;
			endcase
		end
		return '{hi: resp_word[15:8], lo: resp_word[7:0], burn: burn_hold};
	endfunction

	// ------------------------------------------------------------------------
	// item driver: bursts of random length with random gaps
	// ------------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin : item_drive
		beat_t nxt;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				replies_due.push_back(respond_to_beat(item_ch.op, item_ch.cmd, item_ch.param));
			if (!item_ch.valid || item_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					item_ch.valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					nxt = pending_beats.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.op <= nxt.op;
					item_ch.cmd <= nxt.cmd;
					item_ch.param <= nxt.param;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
					end else begin
						burst_left--;
					end
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// result sink: stall pattern plus one long hold-off to back the block up
	// ------------------------------------------------------------------------
	int sink_beats = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int pattern_left = 0;
	int ready_pct = 100;

	always @(posedge clk) begin : result_sink
		if (result_ch.valid && result_ch.ready)
			sink_beats++;
		if (!hold_done && sink_beats >= 100) begin
			hold_left = 400;
			hold_done = 1'b1;
		end
		if (pattern_left == 0) begin
			pattern_left = $urandom_range(16, 96);
			case ($urandom_range(0, 4))
				0, 1:    ready_pct = 100;
				2:       ready_pct = 80;
				3:       ready_pct = 50;
				default: ready_pct = 20;
			endcase
		end else begin
			pattern_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(0, 99) < ready_pct);
		end
	end

	// ------------------------------------------------------------------------
	// response monitor
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		reply_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			n_replies++;
			if (replies_due.size() == 0) begin
				$error("response beat with no command outstanding");
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				if (result_ch.resp_high !== want.hi) begin
					$error("resp_high: expected %0h, got %0h", want.hi, result_ch.resp_high);
					mismatches++;
				end
				if (result_ch.resp_low !== want.lo) begin
					$error("resp_low: expected %0h, got %0h", want.lo, result_ch.resp_low);
					mismatches++;
				end
				if (result_ch.burn_time !== want.burn) begin
					$error("burn_time: expected %0h, got %0h", want.burn, result_ch.burn_time);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	task automatic push_beat(logic op, logic [7:0] cmd, logic [7:0] param);
		pending_beats.push_back('{op: op, cmd: cmd, param: param});
		n_issued++;
	endtask

	task automatic write_register(cfg_index_t idx, logic [15:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_BURN_STEP:   cfg_now.burn_step = value;
			CFG_TEMPERATURE: cfg_now.temperature_word = value;
			default:         cfg_now.status_word = value;
		endcase
	endtask

	task automatic set_registers(logic [15:0] step, logic [15:0] temp, logic [15:0] stat);
		write_register(CFG_BURN_STEP, step);
		write_register(CFG_TEMPERATURE, temp);
		write_register(CFG_STATUS, stat);
	endtask

	// block is idle once every beat sent has come back
	task automatic settle();
		while (n_replies < n_issued)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_command();
		case ($urandom_range(0, 11))
			0, 1:    return CMD_DEPLOY_FIRST + 8'($urandom_range(0, 3));
			2:       return CMD_OVERRIDE_FIRST + 8'($urandom_range(0, 3));
			3, 4:    return CMD_SEQUENTIAL;
			5:       return CMD_COUNT_FIRST + 8'($urandom_range(0, 3));
			6, 7:    return CMD_TIMER_FIRST + 8'($urandom_range(0, 3));
			8:       return CMD_TEMPERATURE;
			9:       return CMD_STATUS;
			10: begin
				case ($urandom_range(0, 3))
					0:       return CMD_NOP_A9;
					1:       return CMD_NOP_AA;
					2:       return CMD_NOP_AD;
					default: return 8'hAC;
				endcase
			end
			default: return 8'($urandom);
		endcase
	endfunction

	// mostly a command followed by a few polls; some stray beats and lone commands
	task automatic random_run(int count);
		int sent;
		int polls;
		int roll;
		sent = 0;
		while (sent < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				push_beat(1'($urandom), 8'($urandom), 8'($urandom));
				sent++;
			end else begin
				push_beat(OP_COMMAND, pick_command(), 8'($urandom));
				polls = (roll < 13) ? 0 : $urandom_range(1, 4);
				repeat (polls)
					push_beat(OP_POLL, 8'($urandom), 8'($urandom));
				sent += 1 + polls;
			end
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.op = OP_COMMAND;
		item_ch.cmd = '0;
		item_ch.param = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_BURN_STEP;
		cfg_ch.data = '0;
		n_issued = 0;
		n_replies = 0;
		mismatches = 0;
		cfg_now = '{burn_step: BURN_STEP_RESET, temperature_word: TEMPERATURE_RESET,
			status_word: STATUS_RESET};
		held_cmd = '0;
		held_param = '0;
		once_flags = '0;
		seq_ant = '0;
		burn_hold = '0;
		resp_word = '0;
		for (int i = 0; i < NUM_ANT; i++) begin
			ant_count[i] = '0;
			ant_timer[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass at reset register values
		push_beat(OP_POLL, 8'hFF, 8'hFF);
		push_beat(OP_COMMAND, CMD_DEPLOY_FIRST, 8'hFF);
		push_beat(OP_POLL, 8'h00, 8'h00);
		push_beat(OP_POLL, 8'h00, 8'h00);
		push_beat(OP_COMMAND, CMD_OVERRIDE_LAST, 8'h00);
		push_beat(OP_POLL, 8'h00, 8'h00);
		push_beat(OP_COMMAND, CMD_SEQUENTIAL, 8'h01);
		push_beat(OP_POLL, 8'h00, 8'h00);
		push_beat(OP_POLL, 8'h00, 8'h00);
		push_beat(OP_COMMAND, CMD_COUNT_FIRST, 8'h00);
		push_beat(OP_POLL, 8'h00, 8'h00);
		push_beat(OP_COMMAND, CMD_TIMER_LAST, 8'h00);
		push_beat(OP_POLL, 8'h00, 8'h00);
		push_beat(OP_POLL, 8'h00, 8'h00);
		push_beat(OP_COMMAND, CMD_TEMPERATURE, 8'h00);
		push_beat(OP_POLL, 8'h00, 8'h00);
		push_beat(OP_COMMAND, CMD_STATUS, 8'h00);
		push_beat(OP_POLL, 8'h00, 8'h00);
		push_beat(OP_COMMAND, CMD_NOP_A9, 8'h00);
		push_beat(OP_POLL, 8'h00, 8'h00);
		push_beat(OP_COMMAND, CMD_NOP_AA, 8'h00);
		push_beat(OP_POLL, 8'h00, 8'h00);
		push_beat(OP_COMMAND, 8'hFF, 8'hFF);
		push_beat(OP_POLL, 8'hFF, 8'hFF);
		push_beat(OP_POLL, 8'h00, 8'h00);
		settle();

		set_registers(16'hFFFF, 16'h0000, 16'h0000);
		random_run(150);
		settle();

		set_registers(16'h0000, 16'hFFFF, 16'hFFFF);
		random_run(150);
		settle();

		// counter wrap on antenna 1
		set_registers(16'h0001, 16'($urandom), 16'($urandom));
		for (int i = 0; i < 257; i++) begin
			push_beat(OP_COMMAND, CMD_DEPLOY_FIRST + 8'd1, 8'(i));
			push_beat(OP_POLL, 8'($urandom), 8'($urandom));
		end
		push_beat(OP_COMMAND, CMD_COUNT_FIRST + 8'd1, 8'h00);
		push_beat(OP_POLL, 8'h00, 8'h00);
		random_run(150);
		settle();

		// timer count on antenna 2: clear, then a run of override passes
		set_registers(16'($urandom), 16'($urandom), 16'($urandom));
		random_run(150);
		push_beat(OP_COMMAND, CMD_TIMER_FIRST + 8'd2, 8'h00);
		push_beat(OP_POLL, 8'h00, 8'h00);
		push_beat(OP_COMMAND, CMD_OVERRIDE_FIRST + 8'd2, 8'h80);
		repeat (50)
			push_beat(OP_POLL, 8'($urandom), 8'($urandom));
		push_beat(OP_COMMAND, CMD_TIMER_FIRST + 8'd2, 8'h00);
		push_beat(OP_POLL, 8'h00, 8'h00);
		settle();

		set_registers(16'($urandom), 16'($urandom), 16'($urandom));
		random_run(150);
		settle();

		repeat (10) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : watchdog
		#400us;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/dcr_pkg.sv
hdl/dcr_if.sv
hdl/dcr_decode.sv
hdl/dcr_cfg_regs.sv
hdl/dcr_exec.sv
hdl/deploy_command_responder_core.sv
tb/tb_top.sv
